[src/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[src/stir_pkg.sv]
package stir_pkg;

    localparam int KEY_W               = 32;
    localparam int VAL_W               = 31;
    localparam int IDX_W               = 7;
    localparam int CFG_W               = 8;
    localparam int FRAC_W              = 16;
    localparam int RATIO_W             = 48;
    localparam int DIVIDEND_W          = VAL_W + FRAC_W;
    localparam int REM_W               = VAL_W + 1;
    localparam int DEFAULT_TABLE_DEPTH = 128;

    // flips the sign bit so signed keys sort as unsigned
    localparam logic [KEY_W-1:0] SIGN_BIAS = {1'b1, {(KEY_W-1){1'b0}}};

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic               done;
        logic [RATIO_W-1:0] quotient;
    } div_status_t;

endpackage

[src/step_table_index_ratio_unit.sv]
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+------------------------------------------
// command   | in        | start, busy              | opcode, entry_index, entry_key,
//           |           |                          | entry_value, from_key, to_key
// result    | out       | done (one-cycle strobe)  | ratio_q16, divide_by_zero
// config    | in        | cfg_valid, cfg_ready     | cfg_data (entry_count)
//
// a load beat gives no result
// a query beat keeps busy high through, for each key, a head step and a scan of
// up to n active entries, then the divide step; the single table read port
// and the one-bit-a-cycle divider set its length, and the next beat can be
// accepted once busy falls
// a zero divisor skips the divider
// reset is asynchronous and clears control state and entry_count to one;
// the table contents are not cleared
// busy stays high for the whole query; results cannot be stalled
module step_table_index_ratio_unit
    import stir_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // command
    input  logic                      start,
    output logic                      busy,
    input  logic                      opcode,
    input  logic [IDX_W-1:0]          entry_index,
    input  logic signed [KEY_W-1:0]   entry_key,
    input  logic [VAL_W-1:0]          entry_value,
    input  logic signed [KEY_W-1:0]   from_key,
    input  logic signed [KEY_W-1:0]   to_key,
    // result
    output logic                      done,
    output logic [RATIO_W-1:0]        ratio_q16,
    output logic                      divide_by_zero,
    // config
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = ($clog2(TABLE_DEPTH + 1) > CFG_W) ?
                            $clog2(TABLE_DEPTH + 1) : CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_SCAN,
        S_DIV
    } state_t;

    state_t              state_reg, state_next;
    logic                pass_reg, pass_next;        // 0 looks up from_key, 1 to_key
    logic [KEY_W-1:0]    from_reg, from_next;        // biased keys
    logic [KEY_W-1:0]    to_reg, to_next;
    logic [KEY_W-1:0]    k0_reg, k0_next;            // entry 0, kept for both keys
    logic [VAL_W-1:0]    v0_reg, v0_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;          // entry whose data is on rd_entry
    logic [VAL_W-1:0]    yfrom_reg, yfrom_next;
    logic [CFG_W-1:0]    count_reg, count_next;
    logic                done_reg, done_next;
    logic [RATIO_W-1:0]  ratio_reg, ratio_next;
    logic                dbz_reg, dbz_next;

    logic                accept;
    logic                wr_en;
    logic [CNT_W-1:0]    wr_idx_ext;
    entry_t              wr_entry;
    logic [ADDR_W-1:0]   rd_addr;
    entry_t              rd_entry;
    logic [CNT_W-1:0]    count_ext;
    logic [CNT_W-1:0]    active;
    logic [CNT_W-1:0]    active_m1;
    logic [ADDR_W-1:0]   last_idx;
    logic [KEY_W-1:0]    cur_key;
    logic                le_k0;
    logic                stop;
    logic [VAL_W-1:0]    found;
    logic                div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    div_status_t         div_status;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;

    // load path: out-of-range indexes are dropped
    assign wr_idx_ext     = CNT_W'(entry_index);
    assign wr_en          = accept && (opcode == OP_LOAD) &&
                            (wr_idx_ext < CNT_W'(TABLE_DEPTH));
    assign wr_entry.key   = $unsigned(entry_key) ^ SIGN_BIAS;
    assign wr_entry.value = entry_value;

    // entry_count clamped to 1..TABLE_DEPTH
    always_comb
    begin
        count_ext = CNT_W'(count_reg);
        if (count_ext == '0)
        begin
            active = CNT_W'(1);
        end
        else if (count_ext > CNT_W'(TABLE_DEPTH))
        begin
            active = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            active = count_ext;
        end
        active_m1 = active - 1'b1;
        last_idx  = active_m1[ADDR_W-1:0];
    end

    // scan stops at an entry at or below the key, at entry 0, or if the key <= k0
    assign cur_key      = pass_reg ? to_reg : from_reg;
    assign le_k0        = (cur_key <= k0_reg);
    assign stop         = le_k0 || (pos_reg == '0) || !(cur_key < rd_entry.key);
    assign found        = le_k0 ? v0_reg : rd_entry.value;
    assign div_dividend = {found, {FRAC_W{1'b0}}};

    stir_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_idx_ext[ADDR_W-1:0]),
        .wr_entry (wr_entry),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    stir_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (yfrom_reg),
        .status   (div_status)
    );

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        from_next  = from_reg;
        to_next    = to_reg;
        k0_next    = k0_reg;
        v0_next    = v0_reg;
        pos_next   = pos_reg;
        yfrom_next = yfrom_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        ratio_next = ratio_reg;
        dbz_next   = dbz_reg;
        rd_addr    = '0;
        div_start  = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            count_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // entry 0 is read every idle cycle, ready for the head step
                rd_addr = '0;
                if (accept && (opcode == OP_QUERY))
                begin
                    from_next  = $unsigned(from_key) ^ SIGN_BIAS;
                    to_next    = $unsigned(to_key) ^ SIGN_BIAS;
                    pass_next  = 1'b0;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (!pass_reg)
                begin
                    k0_next = rd_entry.key;
                    v0_next = rd_entry.value;
                end
                rd_addr    = last_idx;
                pos_next   = last_idx;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // read one entry ahead on the chance that the scan goes on
                rd_addr = pos_reg - 1'b1;
                if (!stop)
                begin
                    pos_next = pos_reg - 1'b1;
                end
                else if (!pass_reg)
                begin
                    yfrom_next = found;
                    pass_next  = 1'b1;
                    state_next = S_HEAD;
                end
                else if (yfrom_reg == '0)
                begin
                    done_next  = 1'b1;
                    ratio_next = '1;
                    dbz_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    done_next  = 1'b1;
                    ratio_next = div_status.quotient;
                    dbz_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
            from_reg  <= '0;
            to_reg    <= '0;
            k0_reg    <= '0;
            v0_reg    <= '0;
            pos_reg   <= '0;
            yfrom_reg <= '0;
            count_reg <= CFG_W'(1);
            done_reg  <= 1'b0;
            ratio_reg <= '0;
            dbz_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            from_reg  <= from_next;
            to_reg    <= to_next;
            k0_reg    <= k0_next;
            v0_reg    <= v0_next;
            pos_reg   <= pos_next;
            yfrom_reg <= yfrom_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            ratio_reg <= ratio_next;
            dbz_reg   <= dbz_next;
        end
    end

    assign done           = done_reg;
    assign ratio_q16      = ratio_reg;
    assign divide_by_zero = dbz_reg;

    // checks
`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_dbz_saturates, clk, rst_n, done && divide_by_zero, ratio_q16 == '1, "zero divisor result not saturated")
    `ASSERT_IMPLIES(a_done_after_busy, clk, rst_n, done, $past(busy), "result beat without a query in flight")
    `ASSERT_NEXT(a_query_goes_busy, clk, rst_n, accept && (opcode == OP_QUERY), busy, "query beat did not start the sequencer")
    `ASSERT_NEXT(a_load_no_result, clk, rst_n, accept && (opcode == OP_LOAD), !done, "load beat produced a result")
    `ASSERT_IMPLIES(a_div_done_in_div, clk, rst_n, div_status.done, state_reg == S_DIV, "divider finished outside the divide step")

endmodule

[src/stir_table.sv]
module stir_table
    import stir_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_entry,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_entry
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_entry_reg;

    // one write port, one read port with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

[src/stir_div.sv]
module stir_div
    import stir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [VAL_W-1:0]      divisor,
    output div_status_t           status
);

    localparam int STEPS = DIVIDEND_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [VAL_W-1:0]      dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [REM_W-1:0]      shifted;
    logic [REM_W:0]        diff;
    logic                  fits;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        shifted   = {rem_reg[REM_W-2:0], quo_reg[DIVIDEND_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        fits      = ~diff[REM_W];
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[REM_W-1:0] : shifted;
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.done     = done_reg;
    assign status.quotient = RATIO_W'(quo_reg);

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import stir_pkg::*;

    localparam int DEPTH         = DEFAULT_TABLE_DEPTH;
    localparam int ITEM_TARGET   = 750;
    // margin so that a trailing load has settled
    localparam int SETTLE_CYCLES = 4;
    // quiet tail after the drain, longer than the longest query
    localparam int TAIL_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 5000;

    localparam logic [KEY_W-1:0]   KEY_MIN   = 32'h8000_0000;
    localparam logic [KEY_W-1:0]   KEY_MAX   = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]   VAL_MAX   = 31'h7FFF_FFFF;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 48'h0000_0001_0000;
    localparam logic [RATIO_W-1:0] RATIO_TOP = 48'h7FFF_FFFF_0000;
    localparam logic [RATIO_W-1:0] RATIO_SAT = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic             opcode;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [KEY_W-1:0] from_k;
        logic [KEY_W-1:0] to_k;
    } cmd_t;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic               dbz;
    } ratio_t;

    typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_COUNT} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        cmd_t             cmd;
        logic [CFG_W-1:0] count;
        logic             typed;
        ratio_t           want;
    } row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    opcode;
    logic [IDX_W-1:0]        entry_index;
    logic signed [KEY_W-1:0] entry_key;
    logic [VAL_W-1:0]        entry_value;
    logic signed [KEY_W-1:0] from_key;
    logic signed [KEY_W-1:0] to_key;
    logic                    done;
    logic [RATIO_W-1:0]      ratio_q16;
    logic                    divide_by_zero;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data;

    // shadow copy of the step table and the count register
    logic [KEY_W-1:0] key_tab [DEPTH];
    logic [VAL_W-1:0] val_tab [DEPTH];
    bit               loaded  [DEPTH];
    logic [CFG_W-1:0] count_reg = 8'd1;

    // ratios owed by the block, oldest first
    ratio_t pending_ratios[$];
    row_t   directed_rows[$];

    int errors = 0;
    int items = 0;
    int quiet_cycles = 0;
    bit burst = 1'b0;

    step_table_index_ratio_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .entry_index    (entry_index),
        .entry_key      (entry_key),
        .entry_value    (entry_value),
        .from_key       (from_key),
        .to_key         (to_key),
        .done           (done),
        .ratio_q16      (ratio_q16),
        .divide_by_zero (divide_by_zero),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // ratio predictor
    // ------------------------------------------------------------------

    // zero means one, anything past the table depth means the whole table
    function automatic int active_entries();
        if (count_reg == 0)
            return 1;
        if (count_reg > DEPTH)
            return DEPTH;
        return int'(count_reg);
    endfunction

    // value of the last entry whose key is at most k, entry 0 at or below its key;
    // the downward walk stops at entry 0 even for an unsorted table
    function automatic logic [VAL_W-1:0] step_value(logic [KEY_W-1:0] k);
        int pos;
        if ($signed(k) <= $signed(key_tab[0]))
            return val_tab[0];
        pos = active_entries() - 1;
        while (pos > 0 && $signed(k) < $signed(key_tab[IDX_W'(pos)]))
            pos--;
        return val_tab[IDX_W'(pos)];
    endfunction

    // to-value over from-value in Q32.16, truncated; a zero divisor flags and saturates
    function automatic ratio_t predict_ratio(logic [KEY_W-1:0] from_k, logic [KEY_W-1:0] to_k);
        ratio_t     r;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        num = 64'(step_value(to_k));
        den = 64'(step_value(from_k));
        if (den == 0)
        begin
            r.ratio = RATIO_SAT;
            r.dbz   = 1'b1;
        end
        else
        begin
            num     = num << FRAC_W;
            q       = num / den;
            r.ratio = (q[63:RATIO_W] != 0) ? RATIO_SAT : q[RATIO_W-1:0];
            r.dbz   = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // every field random, so the fields the opcode ignores still toggle
    function automatic cmd_t rand_cmd();
        cmd_t c;
        c.opcode = 1'($urandom_range(0, 1));
        c.idx    = IDX_W'($urandom);
        c.key    = $urandom;
        c.val    = VAL_W'($urandom);
        c.from_k = $urandom;
        c.to_k   = $urandom;
        return c;
    endfunction

    // zero now and then for divide-by-zero, small values for readable ratios
    function automatic logic [VAL_W-1:0] rand_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return '0;
            1:       return VAL_MAX;
            2:       return VAL_W'($urandom_range(1, 16));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // query keys: mostly on or next to a table key, so the step edges get hit
    function automatic logic [KEY_W-1:0] pick_key(int n);
        int               sel;
        logic [KEY_W-1:0] k;
        sel = $urandom_range(0, 9);
        k   = key_tab[IDX_W'($urandom_range(0, n - 1))];
        case (sel)
            0, 1, 2, 3: return k;
            4:          return k + 1;
            5:          return k - 1;
            6:          return KEY_MIN;
            7:          return KEY_MAX;
            default:    return $urandom;
        endcase
    endfunction

    // idle cycles before a beat: mostly none, some short, a few long
    function automatic int pick_gap();
        int sel;
        if (burst)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        if (sel < 85)
            return $urandom_range(1, 3);
        if (sel < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic void add_load(int idx, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        row_t r;
        r            = '0;
        r.kind       = ROW_LOAD;
        r.cmd        = rand_cmd();
        r.cmd.opcode = OP_LOAD;
        r.cmd.idx    = IDX_W'(idx);
        r.cmd.key    = key;
        r.cmd.val    = val;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_query(logic [KEY_W-1:0] from_k, logic [KEY_W-1:0] to_k,
                                      bit typed, logic [RATIO_W-1:0] ratio, logic dbz);
        row_t r;
        r            = '0;
        r.kind       = ROW_QUERY;
        r.cmd        = rand_cmd();
        r.cmd.opcode = OP_QUERY;
        r.cmd.from_k = from_k;
        r.cmd.to_k   = to_k;
        r.typed      = typed;
        r.want.ratio = ratio;
        r.want.dbz   = dbz;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_count(logic [CFG_W-1:0] n);
        row_t r;
        r       = '0;
        r.kind  = ROW_COUNT;
        r.cmd   = rand_cmd();
        r.count = n;
        directed_rows.push_back(r);
    endfunction

    // one command beat; start stays up after acceptance so a back-to-back beat
    // needs only one assignment per edge
    task automatic send(input cmd_t c, input bit typed, input ratio_t want);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start       <= 1'b1;
        opcode      <= c.opcode;
        entry_index <= c.idx;
        entry_key   <= c.key;
        entry_value <= c.val;
        from_key    <= c.from_k;
        to_key      <= c.to_k;
        do
            @(posedge clk);
        while (busy);
        // beat accepted at this edge
        if (c.opcode == OP_LOAD)
        begin
            key_tab[c.idx] = c.key;
            val_tab[c.idx] = c.val;
            loaded[c.idx]  = 1'b1;
        end
        else if (typed)
            pending_ratios.push_back(want);
        else
            pending_ratios.push_back(predict_ratio(c.from_k, c.to_k));
        items++;
    endtask

    // hold off until every owed result is back and a trailing load has settled
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_ratios.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // entry_count write, only ever with the block idle
    task automatic set_count(input logic [CFG_W-1:0] n);
        drain();
        repeat (pick_gap()) @(negedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do
            @(posedge clk);
        while (!cfg_ready);
        count_reg = n;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ascending keys with a random stride; dense strides give duplicate keys,
    // overflow past the top clamps to the largest key
    task automatic load_entries(input int n, input bit fresh);
        cmd_t        c;
        longint      cur;
        int unsigned stride_max;
        int          mode;
        int          i;
        mode = $urandom_range(0, 2);
        if (mode == 0)
            stride_max = 3;
        else if (mode == 1)
            stride_max = 4096;
        else
            stride_max = 32'hFFFF_FFFF / n;
        if (mode == 2)
            cur = -64'sd2147483648;
        else
            cur = $signed($urandom);
        cur += $urandom_range(0, stride_max);
        for (i = 0; i < n; i++)
        begin
            if (fresh || !loaded[IDX_W'(i)])
            begin
                c        = rand_cmd();
                c.opcode = OP_LOAD;
                c.idx    = IDX_W'(i);
                c.key    = (cur > 64'sd2147483647) ? KEY_MAX : cur[KEY_W-1:0];
                c.val    = rand_value();
                send(c, 1'b0, '0);
            end
            cur += $urandom_range(0, stride_max);
        end
    endtask

    // ------------------------------------------------------------------
    // result checker: every strobe must match the oldest owed ratio
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        ratio_t want;
        if (rst_n && done)
        begin
            if (pending_ratios.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing owed, ratio_q16 %h divide_by_zero %b",
                         $time, ratio_q16, divide_by_zero);
            end
            else
            begin
                want = pending_ratios.pop_front();
                if (ratio_q16 !== want.ratio)
                begin
                    errors++;
                    $display("%0t: ratio_q16 mismatch, expected %h, actual %h",
                             $time, want.ratio, ratio_q16);
                end
                if (divide_by_zero !== want.dbz)
                begin
                    errors++;
                    $display("%0t: divide_by_zero mismatch, expected %b, actual %b",
                             $time, want.dbz, divide_by_zero);
                end
            end
        end
    end

    // watchdog: too long with no command beat, no result and no register write
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        row_t             row;
        cmd_t             c;
        ratio_t           none;
        logic [CFG_W-1:0] n;
        int               eff;
        int               phase;
        int               nq;
        int               sel;
        int               i;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        opcode      <= OP_LOAD;
        entry_index <= '0;
        entry_key   <= '0;
        entry_value <= '0;
        from_key    <= '0;
        to_key      <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        none = '0;

        // count is one after reset: both keys always land on entry 0
        add_load(0, -32'sd100, 31'd1);
        add_query(KEY_MIN, KEY_MAX, 1'b1, RATIO_ONE, 1'b0);
        add_query(KEY_MAX, KEY_MIN, 1'b1, RATIO_ONE, 1'b0);
        // zero divisor
        add_load(0, 32'd0, 31'd0);
        add_query(32'd0, 32'd0, 1'b1, RATIO_SAT, 1'b1);
        add_load(0, KEY_MAX, VAL_MAX);
        add_query(KEY_MIN, KEY_MAX, 1'b1, RATIO_ONE, 1'b0);
        // four-step table, last step worth zero
        add_load(0, -32'sd1000, 31'd1);
        add_load(1, 32'd0, VAL_MAX);
        add_load(2, 32'd1000, 31'd3);
        add_load(3, KEY_MAX, 31'd0);
        add_count(8'd4);
        // largest value over one: top quotient
        add_query(KEY_MIN, 32'd0, 1'b1, RATIO_TOP, 1'b0);
        add_query(KEY_MAX, KEY_MIN, 1'b1, RATIO_SAT, 1'b1);
        // just below, on and just above the step edges
        add_query(32'd999, 32'd1000, 1'b0, '0, 1'b0);
        add_query(32'd1000, -32'sd1000, 1'b0, '0, 1'b0);
        add_query(-32'sd999, -32'sd1001, 1'b0, '0, 1'b0);
        add_query(KEY_MAX - 1, 32'd5, 1'b0, '0, 1'b0);
        // unsorted keys: entry 2 now below entry 0
        add_load(2, -32'sd5000, 31'd7);
        add_query(32'd500, 32'd1000, 1'b0, '0, 1'b0);
        add_query(-32'sd6000, KEY_MAX, 1'b0, '0, 1'b0);
        // a count of zero behaves as one
        add_count(8'd0);
        add_query(KEY_MAX, KEY_MIN, 1'b1, RATIO_ONE, 1'b0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows
        for (i = 0; i < directed_rows.size(); i++)
        begin
            row = directed_rows[i];
            if (row.kind == ROW_COUNT)
                set_count(row.count);
            else
                send(row.cmd, row.typed, row.want);
        end

        // random phases: new count, table loaded with sorted keys, then a run
        // of queries with the odd stray load and the odd full pause
        phase = 0;
        while (items < ITEM_TARGET)
        begin
            burst = ($urandom_range(0, 9) < 3);
            if (phase == 1)
                n = 8'd128;
            else if (phase == 4)
                n = 8'd255;
            else
            begin
                sel = $urandom_range(0, 19);
                case (sel)
                    0:       n = 8'd0;
                    1:       n = 8'd1;
                    2:       n = CFG_W'($urandom_range(17, 127));
                    default: n = CFG_W'($urandom_range(2, 16));
                endcase
            end
            set_count(n);
            eff = active_entries();
            // sometimes keep the old contents and only fill the holes
            load_entries(eff, $urandom_range(0, 3) != 0);
            nq = (eff > 32) ? 10 : $urandom_range(10, 40);
            repeat (nq)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 3)
                    drain();
                c = rand_cmd();
                if (sel < 12)
                begin
                    // stray load anywhere in the table, may unsort it
                    c.opcode = OP_LOAD;
                    c.val    = rand_value();
                end
                else
                begin
                    c.opcode = OP_QUERY;
                    c.from_k = pick_key(eff);
                    c.to_k   = pick_key(eff);
                end
                send(c, 1'b0, none);
            end
            phase++;
        end

        // everything owed must come back, then nothing more may show up
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
